### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define RRQS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define RRQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define RRQS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler package
// Item kind codes, register indexes, fixed field widths and shared structs.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int KIND_W = 3;
  localparam int TID_W  = 8;
  localparam int TICK_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [TICK_W-1:0] QUANTUM_RESET = 8'd3;

  localparam logic [KIND_W-1:0] KIND_FORK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_YIELD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXIT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_START = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 2'd1;

  typedef struct packed {
    logic pop;
    logic push;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [TID_W-1:0] cur_tid;
    logic             running;
    logic             switched;
    logic [TID_W-1:0] prev_tid;
    logic [TID_W-1:0] new_tid;
    logic             fork_ok;
    logic             all_done;
  } res_t;

endpackage

### design/rrqs_queue.sv
// ----------------------------------------------------------------------------
// Run queue
// Circular FIFO of thread ids with head pointer and fill count. A pop and a
// push in the same cycle reuse the slot that the pop frees when full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrqs_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrqs_pkg::q_ctl_t     q_ctl,
  input  logic [ID_BITS-1:0]   push_id,
  output rrqs_pkg::q_stat_t    q_stat,
  output logic [ID_BITS-1:0]   head_id
);
  import rrqs_pkg::*;

  localparam int HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [HEAD_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W:0]     tail_sum;
  logic [HEAD_W-1:0]  tail_idx;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_id      = mem[head_r];

  always_comb begin
    tail_sum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
    if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    tail_idx = tail_sum[HEAD_W-1:0];

    head_nxt = head_r;
    if (q_ctl.pop) begin
      head_nxt = (head_r == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    count_nxt = count_r;
    if (q_ctl.push && !q_ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_ctl.pop && !q_ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      mem[tail_idx] <= push_id;
    end
  end

  `RRQS_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `RRQS_ASSERT_IMP(a_no_overflow, q_ctl.push && q_stat.full, q_ctl.pop)
  `RRQS_ASSERT_IMP(a_no_underflow, q_ctl.pop, !q_stat.empty)

endmodule

### design/rrqs_sched.sv
// ----------------------------------------------------------------------------
// Scheduler core
// Configuration registers, current thread, quantum countdown and id counter,
// with the per-item decision logic that drives the run queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrqs_sched #(
  parameter int ID_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rrqs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rrqs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                fire,
  input  logic [rrqs_pkg::KIND_W-1:0]         kind,
  input  logic                                pend,
  input  rrqs_pkg::q_stat_t                   q_stat,
  input  logic [ID_BITS-1:0]                  head_id,
  output rrqs_pkg::q_ctl_t                    q_ctl,
  output logic [ID_BITS-1:0]                  push_id,
  output rrqs_pkg::res_t                      res
);
  import rrqs_pkg::*;

  localparam int EXT_W = (ID_BITS > TID_W) ? ID_BITS : TID_W;

  logic [TICK_W-1:0]  quantum_r;
  logic               preempt_r;
  logic [ID_BITS-1:0] cur_id_r, cur_id_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  q_ctl_t             ctl;
  logic               rot;
  logic               sw;
  logic               fok;
  logic               done;
  logic [ID_BITS-1:0] prev_id;
  logic [ID_BITS-1:0] new_id;

  function automatic logic [TID_W-1:0] to_tid(input logic [ID_BITS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[TID_W-1:0];
  endfunction

  always_comb begin
    ctl           = '0;
    push_id       = cur_id_r;
    cur_id_nxt    = cur_id_r;
    cur_valid_nxt = cur_valid_r;
    ticks_nxt     = ticks_r;
    next_id_nxt   = next_id_r;
    rot           = 1'b0;
    sw            = 1'b0;
    fok           = 1'b0;
    done          = 1'b0;
    prev_id       = '0;
    new_id        = '0;

    unique case (kind)
      KIND_FORK: begin
        if (!q_stat.full) begin
          ctl.push    = 1'b1;
          push_id     = next_id_r;
          new_id      = next_id_r;
          next_id_nxt = next_id_r + 1'b1;
          fok         = 1'b1;
        end
      end
      KIND_TICK: begin
        if (cur_valid_r && preempt_r && pend) begin
          if (ticks_r <= TICK_W'(1)) begin
            rot = 1'b1;
          end else begin
            ticks_nxt = ticks_r - 1'b1;
          end
        end
      end
      KIND_YIELD: begin
        rot = cur_valid_r;
      end
      KIND_EXIT: begin
        if (cur_valid_r) begin
          prev_id = cur_id_r;
          sw      = 1'b1;
          if (!q_stat.empty) begin
            ctl.pop    = 1'b1;
            cur_id_nxt = head_id;
            ticks_nxt  = quantum_r;
          end else begin
            cur_valid_nxt = 1'b0;
            cur_id_nxt    = '0;
            done          = 1'b1;
          end
        end
      end
      KIND_START: begin
        if (!cur_valid_r) begin
          if (!q_stat.empty) begin
            ctl.pop       = 1'b1;
            cur_id_nxt    = head_id;
            cur_valid_nxt = 1'b1;
            ticks_nxt     = quantum_r;
            next_id_nxt   = next_id_r + 1'b1;
            sw            = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // Rotation requeues the running thread behind the others.
    if (rot) begin
      ticks_nxt = quantum_r;
      if (!q_stat.empty) begin
        ctl.pop    = 1'b1;
        ctl.push   = 1'b1;
        push_id    = cur_id_r;
        prev_id    = cur_id_r;
        cur_id_nxt = head_id;
        sw         = 1'b1;
      end
    end
  end

  assign q_ctl.pop  = ctl.pop & fire;
  assign q_ctl.push = ctl.push & fire;

  always_comb begin
    res.cur_tid  = cur_valid_nxt ? to_tid(cur_id_nxt) : '0;
    res.running  = cur_valid_nxt;
    res.switched = sw;
    res.prev_tid = to_tid(prev_id);
    res.new_tid  = to_tid(new_id);
    res.fork_ok  = fok;
    res.all_done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_RESET;
      preempt_r   <= 1'b0;
      cur_id_r    <= '0;
      cur_valid_r <= 1'b0;
      ticks_r     <= '0;
      next_id_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_QUANTUM: quantum_r <= cfg_wdata;
          CFG_PREEMPT: preempt_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        cur_id_r    <= cur_id_nxt;
        cur_valid_r <= cur_valid_nxt;
        ticks_r     <= ticks_nxt;
        next_id_r   <= next_id_nxt;
      end
    end
  end

  `RRQS_ASSERT_IMP(a_idle_id_zero, !cur_valid_r, cur_id_r == '0)
  `RRQS_ASSERT_NXT(a_fork_counts, fire && fok,
                   next_id_r == ID_BITS'($past(next_id_r) + 1'b1))

endmodule

### design/round_robin_quantum_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler
// Preemptive round-robin thread scheduler with a FIFO run queue, a quantum
// countdown and a thread id counter; one result item per input item.
// ----------------------------------------------------------------------------
// The input channel carries one event per item: fork, timer tick, yield,
// exit or start, with the timer pending bit for ticks. Each accepted item
// gives exactly one result item on the output channel with the running
// thread, switch information, the forked id and the done flag.
// An item is first captured in an input register; when the result register is
// free, the decision logic updates the run queue and scheduler state and loads
// the result register, after which out_valid is high until the item is taken.
// One item is accepted every cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds its item and the input
// register holds one more, after which in_ready falls until out_ready returns.
// The configuration channel is always ready; index 0 sets the quantum in
// ticks and index 1 enables preemption. Write it only while no item is in
// flight. Synchronous reset empties the queue, clears the running thread and
// the id counter, sets the quantum to three and disables preemption.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_quantum_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rrqs_pkg::KIND_W-1:0]        in_kind,
  input  logic                               in_timer_pending,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rrqs_pkg::TID_W-1:0]         out_current_tid,
  output logic                               out_running,
  output logic                               out_switched,
  output logic [rrqs_pkg::TID_W-1:0]         out_previous_tid,
  output logic [rrqs_pkg::TID_W-1:0]         out_new_tid,
  output logic                               out_fork_ok,
  output logic                               out_all_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rrqs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrqs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rrqs_pkg::*;

  logic               a_valid_r, a_valid_nxt;
  logic [KIND_W-1:0]  a_kind_r;
  logic               a_pend_r;
  logic               b_valid_r, b_valid_nxt;
  res_t               res_r;
  res_t               res;
  logic               b_free;
  logic               fire;
  logic               in_fire;
  q_ctl_t             q_ctl;
  q_stat_t            q_stat;
  logic [ID_BITS-1:0] push_id;
  logic [ID_BITS-1:0] head_id;

  assign b_free    = !b_valid_r || out_ready;
  assign fire      = a_valid_r && b_free;
  assign in_ready  = !a_valid_r || b_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (fire) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (fire) begin
      b_valid_nxt = 1'b1;
    end else if (out_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind_r <= in_kind;
      a_pend_r <= in_timer_pending;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  rrqs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ctl   (q_ctl),
    .push_id (push_id),
    .q_stat  (q_stat),
    .head_id (head_id)
  );

  rrqs_sched #(
    .ID_BITS (ID_BITS)
  ) u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .fire      (fire),
    .kind      (a_kind_r),
    .pend      (a_pend_r),
    .q_stat    (q_stat),
    .head_id   (head_id),
    .q_ctl     (q_ctl),
    .push_id   (push_id),
    .res       (res)
  );

  assign out_valid        = b_valid_r;
  assign out_current_tid  = res_r.cur_tid;
  assign out_running      = res_r.running;
  assign out_switched     = res_r.switched;
  assign out_previous_tid = res_r.prev_tid;
  assign out_new_tid      = res_r.new_tid;
  assign out_fork_ok      = res_r.fork_ok;
  assign out_all_done     = res_r.all_done;

  `RRQS_ASSERT_IMP(a_hold_when_blocked, a_valid_r && !b_free, !in_ready)
  `RRQS_ASSERT_NXT(a_result_kept, b_valid_r && !out_ready, b_valid_r)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler testbench
// Drives fork, tick, yield, exit and start items with random gaps and output
// stalls, predicts every result item from a cycle-free scheduler model kept
// in the bench, and compares each result field by field in arrival order.
// Directed items cover the idle scheduler, a lone thread and a full run
// queue; random phases then sweep the quantum and the preemption setting.
// ----------------------------------------------------------------------------
module tb_top;
  import rrqs_pkg::*;

  localparam int SCHED_DEPTH  = 16;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 100;

  localparam logic [KIND_W-1:0]    KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI     = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind;
  logic                  in_timer_pending;
  logic                  out_valid;
  logic                  out_ready;
  logic [TID_W-1:0]      out_current_tid;
  logic                  out_running;
  logic                  out_switched;
  logic [TID_W-1:0]      out_previous_tid;
  logic [TID_W-1:0]      out_new_tid;
  logic                  out_fork_ok;
  logic                  out_all_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Scheduler state as the bench sees it.
  logic [TID_W-1:0]  run_slots [SCHED_DEPTH];
  logic [3:0]        slot_head;
  logic [4:0]        slot_count;
  logic [TID_W-1:0]  cur_tid;
  logic              cur_run;
  logic [TICK_W-1:0] slice_left;
  logic [TID_W-1:0]  next_tid;
  logic [TICK_W-1:0] quantum;
  logic              preempt_on;

  res_t sched_expected [$];
  int   err_count;
  int   items_sent;
  int   results_checked;
  int   settings_used;
  int   idle_cycles;
  logic quiet_run;

  round_robin_quantum_scheduler_unit #(
    .QUEUE_DEPTH(SCHED_DEPTH),
    .ID_BITS    (TID_W)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_timer_pending(in_timer_pending),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_current_tid (out_current_tid),
    .out_running     (out_running),
    .out_switched    (out_switched),
    .out_previous_tid(out_previous_tid),
    .out_new_tid     (out_new_tid),
    .out_fork_ok     (out_fork_ok),
    .out_all_done    (out_all_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void slot_push(logic [TID_W-1:0] tid);
    logic [3:0] idx;
    idx = slot_head + slot_count[3:0];
    run_slots[idx] = tid;
    slot_count++;
  endfunction

  function automatic logic [TID_W-1:0] slot_pop();
    logic [TID_W-1:0] tid;
    tid = run_slots[slot_head];
    slot_head++;
    slot_count--;
    return tid;
  endfunction

  // The running thread goes to the tail and the head takes over; the pop
  // comes first so a full queue frees the slot that the requeue then fills.
  function automatic void rotate_thread(inout res_t r);
    logic [TID_W-1:0] head_tid;
    slice_left = quantum;
    if (slot_count != 0) begin
      head_tid = slot_pop();
      slot_push(cur_tid);
      r.prev_tid = cur_tid;
      r.switched = 1'b1;
      cur_tid = head_tid;
    end
  endfunction

  function automatic res_t sched_predict(logic [KIND_W-1:0] kind, logic pend);
    res_t r;
    r = '0;
    case (kind)
      KIND_FORK: begin
        if (slot_count < SCHED_DEPTH) begin
          r.new_tid = next_tid;
          r.fork_ok = 1'b1;
          slot_push(next_tid);
          next_tid++;
        end
      end
      KIND_TICK: begin
        if (cur_run && preempt_on && pend) begin
          if (slice_left <= 1) rotate_thread(r);
          else slice_left--;
        end
      end
      KIND_YIELD: begin
        if (cur_run) rotate_thread(r);
      end
      KIND_EXIT: begin
        if (cur_run) begin
          r.prev_tid = cur_tid;
          r.switched = 1'b1;
          if (slot_count != 0) begin
            cur_tid = slot_pop();
            slice_left = quantum;
          end else begin
            cur_run = 1'b0;
            cur_tid = '0;
            r.all_done = 1'b1;
          end
        end
      end
      KIND_START: begin
        if (!cur_run) begin
          if (slot_count != 0) begin
            cur_tid = slot_pop();
            cur_run = 1'b1;
            slice_left = quantum;
            next_tid++;
            r.switched = 1'b1;
          end else begin
            r.all_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.cur_tid = cur_run ? cur_tid : '0;
    r.running = cur_run;
    return r;
  endfunction

  task automatic send_item(logic [KIND_W-1:0] kind, logic pend);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_timer_pending <= pend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sched_expected.push_back(sched_predict(kind, pend));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUANTUM: quantum = data;
      CFG_PREEMPT: preempt_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_schedule(logic [TICK_W-1:0] q, logic en);
    cfg_write(CFG_QUANTUM, q);
    cfg_write(CFG_PREEMPT, {7'($urandom_range(0, 127)), en});
    settings_used++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Nothing is running yet, so every item except fork is ignored or done.
  task automatic test_idle_scheduler();
    send_item(KIND_START, 1'b0);
    send_item(KIND_YIELD, 1'b1);
    send_item(KIND_EXIT, 1'b0);
    send_item(KIND_TICK, 1'b1);
  endtask

  // A lone thread with a zero quantum: yield and preemption find an empty
  // queue and keep it running, then its exit leaves the scheduler done.
  task automatic test_lone_thread();
    set_schedule(8'd0, 1'b1);
    send_item(KIND_FORK, 1'b0);
    send_item(KIND_START, 1'b1);
    send_item(KIND_YIELD, 1'b0);
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_EXIT, 1'b1);
  endtask

  // Fill the run queue, refuse one fork, then requeue on a full queue.
  task automatic test_full_queue();
    set_schedule(8'hff, 1'b0);
    repeat (SCHED_DEPTH + 1) send_item(KIND_FORK, 1'($urandom_range(0, 1)));
    send_item(KIND_START, 1'b0);
    send_item(KIND_START, 1'b1);
    send_item(KIND_FORK, 1'b0);
    send_item(KIND_YIELD, 1'b1);
  endtask

  task automatic test_random_traffic();
    int q_tab [PHASE_COUNT]    = '{1, 2, 255, 3, 1, 6, 128, 2};
    int en_tab [PHASE_COUNT]   = '{1, 1, 1, 0, 1, 1, 0, 1};
    int fork_tab [PHASE_COUNT] = '{30, 45, 25, 30, 50, 20, 35, 30};
    int r;
    logic [KIND_W-1:0] kind;
    logic pend;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_schedule(TICK_W'(q_tab[ph]), 1'(en_tab[ph]));
      if (ph == 0) begin
        cfg_write(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
        cfg_write(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
      end
      quiet_run = (ph % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pend = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < fork_tab[ph]) begin
          kind = KIND_FORK;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            kind = KIND_TICK;
            pend = ($urandom_range(0, 99) < 85);
          end else if (r < 65) begin
            kind = KIND_YIELD;
          end else if (r < 85) begin
            kind = KIND_EXIT;
          end else if (r < 96) begin
            kind = KIND_START;
          end else begin
            kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
          end
        end
        send_item(kind, pend);
      end
      quiet_run = 1'b0;
    end
  endtask

  initial begin
    int stall;
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sched_expected.size() == 0) begin
        $error("result item arrived with no item expected");
        err_count++;
      end else begin
        want = sched_expected.pop_front();
        check_field("current_tid", want.cur_tid, out_current_tid);
        check_field("running", want.running, out_running);
        check_field("switched", want.switched, out_switched);
        check_field("previous_tid", want.prev_tid, out_previous_tid);
        check_field("new_tid", want.new_tid, out_new_tid);
        check_field("fork_ok", want.fork_ok, out_fork_ok);
        check_field("all_done", want.all_done, out_all_done);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    err_count        = 0;
    items_sent       = 0;
    results_checked  = 0;
    settings_used    = 0;
    idle_cycles      = 0;
    quiet_run        = 1'b0;
    slot_head        = '0;
    slot_count       = '0;
    cur_tid          = '0;
    cur_run          = 1'b0;
    slice_left       = '0;
    next_tid         = '0;
    quantum          = QUANTUM_RESET;
    preempt_on       = 1'b0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_FORK;
    in_timer_pending <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_QUANTUM;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_scheduler();
    test_lone_thread();
    test_full_queue();
    test_random_traffic();
    drain_results();

    $display("Sent %0d items and checked %0d results over %0d quantum/preemption settings.",
             items_sent, results_checked, settings_used);
    $display("Errors found: %0d.", err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/rrqs_pkg.sv
design/rrqs_queue.sv
design/rrqs_sched.sv
design/round_robin_quantum_scheduler_unit.sv
verif/tb_top.sv
